/* sv/itt_pkg.sv */
// ----------------------------------------------------------------------------
// itt_pkg
// Shared types, constants and UTF-8 helpers for the tag text transcoder.
// ----------------------------------------------------------------------------
package itt_pkg;

  // Count and capacity width (capacity register is 13 bits)
  localparam int CNT_W = 13;
  localparam int LEN_W = 12;
  localparam int CP_W  = 21;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [CNT_W-1:0] CAP_RESET = 13'd128;

  // Encoding selector codes
  localparam logic [7:0] SEL_UTF16_LE = 8'h01;
  localparam logic [7:0] SEL_UTF16_BE = 8'h02;
  localparam logic [7:0] SEL_UTF8     = 8'h03;

  // Byte-order mark bytes
  localparam logic [7:0] BOM_FF = 8'hff;
  localparam logic [7:0] BOM_FE = 8'hfe;

  // Surrogate ranges
  localparam logic [15:0] HI_SURR_FIRST = 16'hd800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hdbff;
  localparam logic [15:0] LO_SURR_FIRST = 16'hdc00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hdfff;
  localparam logic [5:0]  HI_SURR_TOP   = 6'b110110;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  // Trimmed whitespace
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  typedef enum logic [1:0] {
    MODE_AWAIT,
    MODE_UTF16,
    MODE_RAW,
    MODE_LATIN1
  } mode_t;

  typedef enum logic [1:0] {
    CMD_CP,
    CMD_RAW,
    CMD_END
  } cmd_kind_t;

  // One request from front to back: a code point, a raw byte, or the
  // closing length.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [CP_W-1:0]   data;
  } cmd_t;

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] cp_len(input logic [CP_W-1:0] cp);
    logic [2:0] n;
    if (cp < 21'h80)         n = 3'd1;
    else if (cp < 21'h800)   n = 3'd2;
    else if (cp < 21'h10000) n = 3'd3;
    else                     n = 3'd4;
    return n;
  endfunction

  // Byte idx of the UTF-8 form of cp, which is n bytes long
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [2:0] n,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (n)
      3'd1: b = cp[7:0];
      3'd2: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic logic is_trim(input logic [15:0] u);
    return (u == {8'h00, CH_SPACE}) || (u == {8'h00, CH_CR}) || (u == {8'h00, CH_LF});
  endfunction

endpackage

/* sv/itt_front.sv */
// ----------------------------------------------------------------------------
// itt_front
// Accepts payload bytes, tracks encoding state, capacity and trimmed length,
// and issues code point/raw byte/end requests one per cycle unless q_full.
// ----------------------------------------------------------------------------
module itt_front #(
  parameter int CAPACITY_LIMIT = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_capacity,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 in_last_byte,
  output logic                 q_push,
  output itt_pkg::cmd_t        q_cmd,
  input  logic                 q_full
);
  import itt_pkg::*;

  localparam logic [16:0] LIM17 = 17'(CAPACITY_LIMIT);

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_eff;

  mode_t            mode_r, mode_nxt;
  logic             le_r, le_nxt;
  logic             first_r, first_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_v_r, held_v_nxt;
  logic [9:0]       pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic             stop_r, stop_nxt;

  // Issue slots: 0 flushed/combined unit, 1 new unit, 2 end flush, 3 end
  cmd_t             slot_r [4];
  cmd_t             slot_nxt [4];
  logic [3:0]       slot_v_r, slot_v_nxt;
  logic [3:0]       new_v;
  logic [3:0]       sel_oh;
  logic [1:0]       sel;
  logic [3:0]       remaining;
  logic             accept;

  logic [15:0]      u16;
  logic [CNT_W-1:0] ua;
  logic [CNT_W-1:0] ka;
  logic             skip;

  // Effective capacity saturates at the limit
  assign cap_eff = (17'(cap_r) > LIM17) ? LIM17[CNT_W-1:0] : cap_r;

  // Issue the lowest pending slot
  always_comb begin
    sel    = 2'd0;
    sel_oh = 4'b0000;
    if (slot_v_r[0]) begin
      sel = 2'd0; sel_oh = 4'b0001;
    end else if (slot_v_r[1]) begin
      sel = 2'd1; sel_oh = 4'b0010;
    end else if (slot_v_r[2]) begin
      sel = 2'd2; sel_oh = 4'b0100;
    end else if (slot_v_r[3]) begin
      sel = 2'd3; sel_oh = 4'b1000;
    end
  end

  assign q_push    = (|slot_v_r) && !q_full;
  assign q_cmd     = slot_r[sel];
  assign remaining = slot_v_r & ~(q_push ? sel_oh : 4'b0000);
  assign full      = |remaining;
  assign accept    = push && !full;

  assign u16 = le_r ? {in_byte, held_r} : {held_r, in_byte};

  always_comb begin
    mode_nxt   = mode_r;
    le_nxt     = le_r;
    first_nxt  = first_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    used_nxt   = used_r;
    kept_nxt   = kept_r;
    stop_nxt   = stop_r;
    new_v      = 4'b0000;
    ua         = used_r;
    ka         = kept_r;
    skip       = 1'b0;
    for (int i = 0; i < 4; i++) begin
      slot_nxt[i] = slot_r[i];
    end

    if (accept) begin
      case (mode_r)
        MODE_AWAIT: begin
          le_nxt     = (in_byte == SEL_UTF16_LE);
          first_nxt  = 1'b1;
          held_nxt   = 8'h00;
          held_v_nxt = 1'b0;
          pend_nxt   = 10'd0;
          pend_v_nxt = 1'b0;
          used_nxt   = '0;
          kept_nxt   = '0;
          stop_nxt   = 1'b0;
          if (in_byte == SEL_UTF16_LE || in_byte == SEL_UTF16_BE) begin
            mode_nxt = MODE_UTF16;
          end else if (in_byte == SEL_UTF8) begin
            mode_nxt = MODE_RAW;
          end else begin
            mode_nxt = MODE_LATIN1;
          end
        end
        MODE_UTF16: begin
          if (!stop_r) begin
            if (!held_v_r) begin
              held_nxt   = in_byte;
              held_v_nxt = 1'b1;
            end else begin
              held_nxt   = 8'h00;
              held_v_nxt = 1'b0;
              first_nxt  = 1'b0;
              if (first_r && held_r == BOM_FF && in_byte == BOM_FE) begin
                le_nxt = 1'b1;
              end else if (first_r && held_r == BOM_FE && in_byte == BOM_FF) begin
                le_nxt = 1'b0;
              end else begin
                if (pend_v_r) begin
                  pend_v_nxt = 1'b0;
                  pend_nxt   = 10'd0;
                  new_v[0]   = 1'b1;
                  slot_nxt[0].kind = CMD_CP;
                  if (u16 >= LO_SURR_FIRST && u16 <= LO_SURR_LAST) begin
                    slot_nxt[0].data = SUPP_BASE + {1'b0, pend_r, u16[9:0]};
                    ua   = used_r + 13'd4;
                    skip = 1'b1;
                  end else begin
                    slot_nxt[0].data = {5'd0, HI_SURR_TOP, pend_r};
                    ua = used_r + 13'd3;
                  end
                  // Multi-byte forms are never trimmed
                  ka = ua;
                end
                used_nxt = ua;
                kept_nxt = ka;
                if (!skip) begin
                  if (!(({1'b0, ua} + 14'd4) < {1'b0, cap_eff}) || u16 == 16'h0000) begin
                    stop_nxt = 1'b1;
                  end else if (u16 >= HI_SURR_FIRST && u16 <= HI_SURR_LAST) begin
                    pend_nxt   = u16[9:0];
                    pend_v_nxt = 1'b1;
                  end else begin
                    new_v[1]         = 1'b1;
                    slot_nxt[1].kind = CMD_CP;
                    slot_nxt[1].data = {5'd0, u16};
                    used_nxt = ua + 13'(cp_len({5'd0, u16}));
                    kept_nxt = is_trim(u16) ? ka : used_nxt;
                  end
                end
              end
            end
          end
        end
        MODE_RAW: begin
          // Copy while used < capacity - 1
          if (({1'b0, used_r} + 14'd1) < {1'b0, cap_eff}) begin
            new_v[1]         = 1'b1;
            slot_nxt[1].kind = CMD_RAW;
            slot_nxt[1].data = {13'd0, in_byte};
            used_nxt = used_r + 13'd1;
            kept_nxt = used_nxt;
          end
        end
        default: begin
          if (!stop_r) begin
            if ((({1'b0, used_r} + 14'd2) < {1'b0, cap_eff}) && in_byte != 8'h00) begin
              new_v[1]         = 1'b1;
              slot_nxt[1].kind = CMD_CP;
              slot_nxt[1].data = {13'd0, in_byte};
              used_nxt = used_r + 13'(cp_len({13'd0, in_byte}));
              kept_nxt = is_trim({8'h00, in_byte}) ? kept_r : used_nxt;
            end else begin
              stop_nxt = 1'b1;
            end
          end
        end
      endcase

      if (in_last_byte) begin
        if (pend_v_nxt) begin
          new_v[2]         = 1'b1;
          slot_nxt[2].kind = CMD_CP;
          slot_nxt[2].data = {5'd0, HI_SURR_TOP, pend_nxt};
          used_nxt = used_nxt + 13'd3;
          kept_nxt = used_nxt;
        end
        new_v[3]         = 1'b1;
        slot_nxt[3].kind = CMD_END;
        slot_nxt[3].data = {9'd0, kept_nxt[LEN_W-1:0]};
        mode_nxt   = MODE_AWAIT;
        le_nxt     = 1'b0;
        first_nxt  = 1'b1;
        held_nxt   = 8'h00;
        held_v_nxt = 1'b0;
        pend_nxt   = 10'd0;
        pend_v_nxt = 1'b0;
        used_nxt   = '0;
        kept_nxt   = '0;
        stop_nxt   = 1'b0;
      end
    end
  end

  assign slot_v_nxt = accept ? new_v : remaining;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      mode_r   <= MODE_AWAIT;
      le_r     <= 1'b0;
      first_r  <= 1'b1;
      held_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      used_r   <= '0;
      kept_r   <= '0;
      stop_r   <= 1'b0;
      slot_v_r <= 4'b0000;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      mode_r   <= mode_nxt;
      le_r     <= le_nxt;
      first_r  <= first_nxt;
      held_v_r <= held_v_nxt;
      pend_v_r <= pend_v_nxt;
      used_r   <= used_nxt;
      kept_r   <= kept_nxt;
      stop_r   <= stop_nxt;
      slot_v_r <= slot_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    pend_r <= pend_nxt;
    for (int i = 0; i < 4; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule

/* sv/itt_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// itt_cmd_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module itt_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  itt_pkg::cmd_t  wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output itt_pkg::cmd_t  rd_data,
  output logic           q_empty
);
  import itt_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, wp_nxt;
  logic [CMDQ_AW-1:0] rp_r, rp_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign q_full  = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rp_r];

  assign wp_nxt  = do_wr ? CMDQ_AW'(wp_r + 1'b1) : wp_r;
  assign rp_nxt  = do_rd ? CMDQ_AW'(rp_r + 1'b1) : rp_r;
  assign cnt_nxt = cnt_r + (CMDQ_AW+1)'(do_wr) - (CMDQ_AW+1)'(do_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

/* sv/itt_back.sv */
// ----------------------------------------------------------------------------
// itt_back
// Expands queued requests into UTF-8 bytes, one result per cycle while
// results are popped, behind an output register.
// ----------------------------------------------------------------------------
module itt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  itt_pkg::cmd_t  q_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_is_end,
  output logic [11:0]    out_text_length
);
  import itt_pkg::*;

  cmd_t        cur_r, cur_nxt;
  logic [2:0]  n_r, n_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        cur_v_r, cur_v_nxt;

  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        oe_r, oe_nxt;
  logic [11:0] ol_r, ol_nxt;

  logic        can_out, emit, done;

  assign can_out = !ov_r || pop;
  assign emit    = cur_v_r && can_out;
  assign done    = emit && ({1'b0, idx_r} == n_r - 3'd1);
  assign q_pop   = (!cur_v_r || done) && !q_empty;

  always_comb begin
    cur_nxt   = cur_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    cur_v_nxt = cur_v_r;
    ov_nxt    = ov_r && !pop;
    ob_nxt    = ob_r;
    oe_nxt    = oe_r;
    ol_nxt    = ol_r;

    if (emit) begin
      ov_nxt  = 1'b1;
      idx_nxt = idx_r + 2'd1;
      case (cur_r.kind)
        CMD_END: begin
          ob_nxt = 8'h00;
          oe_nxt = 1'b1;
          ol_nxt = cur_r.data[LEN_W-1:0];
        end
        CMD_RAW: begin
          ob_nxt = cur_r.data[7:0];
          oe_nxt = 1'b0;
          ol_nxt = '0;
        end
        default: begin
          ob_nxt = utf8_byte(cur_r.data, n_r, idx_r);
          oe_nxt = 1'b0;
          ol_nxt = '0;
        end
      endcase
      if (done) begin
        cur_v_nxt = 1'b0;
      end
    end

    if (q_pop) begin
      cur_nxt   = q_cmd;
      cur_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
      n_nxt     = (q_cmd.kind == CMD_CP) ? cp_len(q_cmd.data) : 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    n_r   <= n_nxt;
    idx_r <= idx_nxt;
    ob_r  <= ob_nxt;
    oe_r  <= oe_nxt;
    ol_r  <= ol_nxt;
  end

  assign empty           = !ov_r;
  assign out_byte        = ob_r;
  assign out_is_end      = oe_r;
  assign out_text_length = ol_r;

endmodule

/* sv/id3_text_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// id3_text_to_utf8_transcoder
// Converts one tag text payload (Latin-1, UTF-16 or UTF-8) to UTF-8 bytes.
// ----------------------------------------------------------------------------
// Feed a payload one byte per push; the first byte selects the encoding
// (1 = UTF-16 LE default, 2 = UTF-16 BE default, a leading BOM overrides;
// 3 = UTF-8 copied raw; anything else Latin-1). Mark the final byte with
// in_last_byte. Each converted UTF-8 byte comes out as one result with
// out_is_end low; the payload closes with one result whose out_is_end is
// high and whose out_text_length is the length after trailing space, CR
// and LF are trimmed (raw UTF-8 is not trimmed). Conversion honors the
// capacity register (buffer size including terminator, saturated at
// CAPACITY_LIMIT); write it only while the block is idle.
//
// Rate: a byte that produces at most one request (a code point, a raw
// byte or the end marker) is taken every cycle while the request queue
// has room; a byte that produces several requests holds full while the
// front issues them. The back side sends one result per cycle while
// results are popped, so sustained throughput is set by the number of
// UTF-8 bytes per input byte (0 to 6, plus the end result) against the
// single-byte result port; a 4-entry request queue absorbs the difference.
// ----------------------------------------------------------------------------
module id3_text_to_utf8_transcoder #(
  parameter int CAPACITY_LIMIT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [12:0] cfg_capacity,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_is_end,
  output logic [11:0] out_text_length
);
  import itt_pkg::*;

  // Front -> queue
  logic  f_push;
  cmd_t  f_cmd;
  logic  q_full;

  // Queue -> back
  cmd_t  b_cmd;
  logic  q_empty;
  logic  b_pop;

  // Front: decodes the encoding, tracks surrogates, capacity and the
  // trimmed length, and issues requests.
  itt_front #(
    .CAPACITY_LIMIT (CAPACITY_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_capacity (cfg_capacity),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .q_push       (f_push),
    .q_cmd        (f_cmd),
    .q_full       (q_full)
  );

  // Decoupling queue so front and back stall independently
  itt_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_data (f_cmd),
    .q_full  (q_full),
    .rd_en   (b_pop),
    .rd_data (b_cmd),
    .q_empty (q_empty)
  );

  // Back: UTF-8 byte expansion into the output register
  itt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_cmd           (b_cmd),
    .q_empty         (q_empty),
    .q_pop           (b_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_is_end      (out_is_end),
    .out_text_length (out_text_length)
  );

endmodule

/* tb/utf8_check_pkg.sv */
// ----------------------------------------------------------------------------
// utf8_check_pkg
// Expected-output tracker for the tag text transcoder testbench.
// ----------------------------------------------------------------------------
// Mirrors the transcoder's payload state byte by byte, queues the UTF-8
// bytes and closing length it should produce, and compares what comes out.
// ----------------------------------------------------------------------------
package utf8_check_pkg;
  import itt_pkg::*;

  // Capacity saturates here (block parameter left at its default)
  localparam int unsigned CAP_CEILING = 4096;

  typedef struct {
    logic [7:0]  data;
    logic        is_end;
    logic [11:0] length;
  } utf8_out_t;

  class utf8_scoreboard;
    utf8_out_t   expected_utf8[$];
    logic [12:0] capacity;
    mode_t       mode;
    bit          little_endian;
    bit          first_unit;
    bit          held_valid;
    bit          pending_valid;
    bit          stopped;
    logic [7:0]  held_byte;
    logic [9:0]  pending_high;
    int unsigned used_count;
    int unsigned kept_length;
    int          checked;
    int          mismatches;

    function new();
      capacity   = CAP_RESET;
      mode       = MODE_AWAIT;
      checked    = 0;
      mismatches = 0;
      clear_payload();
    endfunction

    function void clear_payload();
      little_endian = 0;
      first_unit    = 1;
      held_byte     = '0;
      held_valid    = 0;
      pending_high  = '0;
      pending_valid = 0;
      used_count    = 0;
      kept_length   = 0;
      stopped       = 0;
    endfunction

    function int unsigned room();
      int unsigned cap;
      cap = capacity;
      return (cap > CAP_CEILING) ? CAP_CEILING : cap;
    endfunction

    function int pending();
      return expected_utf8.size();
    endfunction

    // One converted byte; outside raw mode, trailing whitespace does not extend the kept length
    function void push_byte(logic [7:0] b);
      utf8_out_t r;
      r.data   = b;
      r.is_end = 1'b0;
      r.length = '0;
      expected_utf8.push_back(r);
      used_count++;
      if (mode == MODE_RAW || !(b == CH_SPACE || b == CH_CR || b == CH_LF))
        kept_length = used_count;
    endfunction

    function void put_code_point(int unsigned cp);
      if (cp < 'h80) begin
        push_byte(8'(cp));
      end else if (cp < 'h800) begin
        push_byte(8'('hc0 | (cp >> 6)));
        push_byte(8'('h80 | (cp & 'h3f)));
      end else if (cp < 'h10000) begin
        push_byte(8'('he0 | (cp >> 12)));
        push_byte(8'('h80 | ((cp >> 6) & 'h3f)));
        push_byte(8'('h80 | (cp & 'h3f)));
      end else begin
        push_byte(8'('hf0 | ((cp >> 18) & 'h7)));
        push_byte(8'('h80 | ((cp >> 12) & 'h3f)));
        push_byte(8'('h80 | ((cp >> 6) & 'h3f)));
        push_byte(8'('h80 | (cp & 'h3f)));
      end
    endfunction

    function void take_unit(logic [15:0] u);
      int unsigned cp;
      if (pending_valid) begin
        pending_valid = 0;
        if (u >= LO_SURR_FIRST && u <= LO_SURR_LAST) begin
          cp = 32'(SUPP_BASE) + (32'(pending_high) << 10) + 32'(u - LO_SURR_FIRST);
          put_code_point(cp);
          pending_high = '0;
          return;
        end
        // high surrogate without its partner goes out on its own
        put_code_point(32'(HI_SURR_FIRST) + 32'(pending_high));
        pending_high = '0;
      end
      if (!(used_count + 4 < room()) || u == 16'h0000) begin
        stopped = 1;
        return;
      end
      if (u >= HI_SURR_FIRST && u <= HI_SURR_LAST) begin
        pending_high  = 10'(u - HI_SURR_FIRST);
        pending_valid = 1;
        return;
      end
      put_code_point(32'(u));
    endfunction

    // Accepted input byte; returns 0 when the block has nothing to do with it
    function bit note_byte(logic [7:0] b, logic last);
      bit          counted;
      logic [15:0] unit;
      int unsigned lim;
      utf8_out_t   r;
      counted = 1;
      case (mode)
        MODE_AWAIT: begin
          clear_payload();
          if (b == SEL_UTF16_LE || b == SEL_UTF16_BE) begin
            mode          = MODE_UTF16;
            little_endian = (b == SEL_UTF16_LE);
          end else if (b == SEL_UTF8) begin
            mode = MODE_RAW;
          end else begin
            mode = MODE_LATIN1;
          end
        end
        MODE_UTF16: begin
          if (stopped) begin
            counted = 0;
          end else if (!held_valid) begin
            held_byte  = b;
            held_valid = 1;
          end else begin
            held_valid = 0;
            if (first_unit && held_byte == BOM_FF && b == BOM_FE) begin
              little_endian = 1;
            end else if (first_unit && held_byte == BOM_FE && b == BOM_FF) begin
              little_endian = 0;
            end else begin
              unit = little_endian ? {b, held_byte} : {held_byte, b};
              take_unit(unit);
            end
            first_unit = 0;
            held_byte  = '0;
          end
        end
        MODE_RAW: begin
          lim = (room() == 0) ? 0 : room() - 1;
          if (used_count < lim) push_byte(b);
          else counted = 0;
        end
        default: begin
          if (stopped) counted = 0;
          else if (used_count + 2 < room() && b != 8'h00) put_code_point(32'(b));
          else stopped = 1;
        end
      endcase
      if (last) begin
        counted = 1;
        if (pending_valid) begin
          pending_valid = 0;
          put_code_point(32'(HI_SURR_FIRST) + 32'(pending_high));
          pending_high = '0;
        end
        r.data   = 8'h00;
        r.is_end = 1'b1;
        r.length = 12'(kept_length);
        expected_utf8.push_back(r);
        mode = MODE_AWAIT;
        clear_payload();
      end
      return counted;
    endfunction

    function void check_result(logic [7:0] data, logic is_end, logic [11:0] length);
      utf8_out_t want;
      checked++;
      if (expected_utf8.size() == 0) begin
        $error("result with nothing expected: out_byte=%h out_is_end=%b out_text_length=%0d",
               data, is_end, length);
        mismatches++;
        return;
      end
      want = expected_utf8.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, data);
        mismatches++;
      end
      if (is_end !== want.is_end) begin
        $error("out_is_end: expected %b, got %b", want.is_end, is_end);
        mismatches++;
      end
      if (length !== want.length) begin
        $error("out_text_length: expected %0d, got %0d", want.length, length);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* tb/tb_id3_text_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// tb_id3_text_to_utf8_transcoder
// Self-checking testbench for the tag text to UTF-8 transcoder.
// ----------------------------------------------------------------------------
// Feeds whole payloads (Latin-1, UTF-16 with and without byte-order marks,
// raw UTF-8, and random junk) through the push/full side and pops results
// off the empty/pop side. Every accepted byte is run through a scoreboard
// that tracks the block's payload state and queues the expected UTF-8 bytes
// and closing length; every popped result is compared against the head of
// that queue. The capacity register is swept across its extremes between
// phases, with the sender paused until all results are back.
// ----------------------------------------------------------------------------
module tb_id3_text_to_utf8_transcoder;
  timeunit 1ns;
  timeprecision 1ps;

  import itt_pkg::*;
  import utf8_check_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
  localparam int LONG_HOLD   = 300;     // receiver hold-off for back-pressure
  localparam int SETTLE      = 10;      // pipeline settle time after the last result

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_capacity;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        in_last_byte;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_is_end;
  logic [11:0] out_text_length;

  utf8_scoreboard sb = new();

  // Payload under construction, sent front to back
  logic [7:0] payload_bytes[$];

  // Sender pacing
  int unsigned burst_left = 0;
  bit          steady_send = 0;

  // Run statistics
  int unsigned bytes_sent = 0;
  int unsigned counted_items = 0;
  int unsigned payloads = 0;
  int unsigned settings = 1;
  int unsigned cycle_count = 0;

  // Back-pressure requests from the stimulus; the receiver serves them
  int unsigned hold_requests = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  id3_text_to_utf8_transcoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_capacity    (cfg_capacity),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_last_byte    (in_last_byte),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_is_end      (out_is_end),
    .out_text_length (out_text_length)
  );

  // --------------------------------------------------------------------------
  // Watchdog: a hang or a lost result ends the run here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Pop rate rotates through four styles (always ready,
  // one-in-five, coin flip, mostly ready) so stalls land on every phase of
  // the block's output sequencing. A hold-off request from the stimulus
  // drops pop while a counter loaded from LONG_HOLD is counted down here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    int unsigned rx_cycle;
    int unsigned hold_left;
    int unsigned holds_served;
    bit          want;
    if (rst_n !== 1'b1) begin
      pop <= 1'b0;
    end else begin
      // handshake sampled on pre-edge values
      if (pop && !empty) sb.check_result(out_byte, out_is_end, out_text_length);
      rx_cycle++;
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      case ((rx_cycle / 97) % 4)
        0:       want = 1'b1;
        1:       want = (rx_cycle % 5) == 0;
        2:       want = $urandom_range(0, 1);
        default: want = $urandom_range(0, 7) != 0;
      endcase
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= want;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. One request is offered until push && !full at an edge, then
  // handed to the scoreboard. Bursts of random length with random gaps;
  // some bursts are long enough to give stretches with no idling. push is
  // only lowered at a gap, so back-to-back requests keep it high.
  // --------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic last);
    push         <= 1'b1;
    in_byte      <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    if (sb.note_byte(b, last)) counted_items++;
    bytes_sent++;
    if (!steady_send) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_payload();
    foreach (payload_bytes[i])
      offer_byte(payload_bytes[i], i == payload_bytes.size() - 1);
    payloads++;
  endtask

  // Sender goes quiet until every expected result is back, then lets the
  // pipeline settle (bytes that yield nothing may still be in flight).
  task automatic wait_until_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input int unsigned value);
    wait_until_idle();
    cfg_capacity <= 13'(value);
    cfg_we       <= 1'b1;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.capacity = 13'(value);
    settings++;
  endtask

  // --------------------------------------------------------------------------
  // Payload builders
  // --------------------------------------------------------------------------
  function automatic logic [7:0] trim_char();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Mostly short payloads; a few long ones to run into small capacities
  function automatic int unsigned pick_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(24, 60) : $urandom_range(0, 10);
  endfunction

  task automatic add_unit(input logic [15:0] u, input bit le);
    if (le) begin
      payload_bytes.push_back(u[7:0]);
      payload_bytes.push_back(u[15:8]);
    end else begin
      payload_bytes.push_back(u[15:8]);
      payload_bytes.push_back(u[7:0]);
    end
  endtask

  task automatic build_latin1();
    logic [7:0]  sel;
    int unsigned n;
    int unsigned r;
    payload_bytes.delete();
    do sel = 8'($urandom_range(0, 255));
    while (sel == SEL_UTF16_LE || sel == SEL_UTF16_BE || sel == SEL_UTF8);
    payload_bytes.push_back(sel);
    n = pick_length();
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 4)       payload_bytes.push_back(8'h00);       // terminator
      else if (r < 12) payload_bytes.push_back(trim_char());
      else             payload_bytes.push_back(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) payload_bytes.push_back(trim_char());
  endtask

  task automatic build_utf16();
    logic [7:0]  sel;
    logic [15:0] u;
    bit          le;
    int unsigned n;
    payload_bytes.delete();
    sel = $urandom_range(0, 1) ? SEL_UTF16_LE : SEL_UTF16_BE;
    le  = (sel == SEL_UTF16_LE);
    payload_bytes.push_back(sel);
    // optional byte-order mark overriding the selector's default
    case ($urandom_range(0, 4))
      0: begin
        payload_bytes.push_back(BOM_FF);
        payload_bytes.push_back(BOM_FE);
        le = 1;
      end
      1: begin
        payload_bytes.push_back(BOM_FE);
        payload_bytes.push_back(BOM_FF);
        le = 0;
      end
      default: ;
    endcase
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0:       add_unit(16'h0000, le);
        1, 2:    add_unit(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)), le);
        3:       add_unit(16'($urandom_range(LO_SURR_FIRST, LO_SURR_LAST)), le);
        4, 5, 6: begin
          add_unit(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)), le);
          add_unit(16'($urandom_range(LO_SURR_FIRST, LO_SURR_LAST)), le);
        end
        7:           add_unit({8'h00, trim_char()}, le);
        8, 9, 10:    add_unit(16'($urandom_range(1, 'h7f)), le);
        11, 12, 13:  add_unit(16'($urandom_range('h80, 'h7ff)), le);
        default: begin
          do u = 16'($urandom_range('h800, 'hffff));
          while (u >= HI_SURR_FIRST && u <= LO_SURR_LAST);
          add_unit(u, le);
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) add_unit({8'h00, trim_char()}, le);
    // odd trailing byte, dropped by the block
    if ($urandom_range(0, 4) == 0) payload_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_raw();
    int unsigned n;
    payload_bytes.delete();
    payload_bytes.push_back(SEL_UTF8);
    n = pick_length();
    repeat (n)
      payload_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'h00
                                                           : 8'($urandom_range(0, 255)));
  endtask

  // Junk: any selector, any bytes
  task automatic build_noise();
    payload_bytes.delete();
    repeat ($urandom_range(1, 8)) payload_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random payloads until `target` more bytes have been sent
  task automatic run_random(input int unsigned target);
    int unsigned start;
    int unsigned r;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 35)      build_utf16();
      else if (r < 65) build_latin1();
      else if (r < 85) build_raw();
      else             build_noise();
      send_payload();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned caps[$];
    push         <= 1'b0;
    in_byte      <= 8'h00;
    in_last_byte <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_capacity <= CAP_RESET;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed payloads at the reset capacity.
    // Selector alone with the last flag: closes at once, length 0.
    payload_bytes = '{8'h00};
    send_payload();
    // Latin-1: top byte needs two UTF-8 bytes; trailing space and CR trimmed.
    payload_bytes = '{8'h04, 8'hff, CH_SPACE, CH_CR};
    send_payload();
    // LE selector overridden to big-endian by FE FF; surrogate pair combined;
    // a high surrogate followed by a zero unit goes out alone, then the zero
    // stops conversion and the trailing byte is ignored.
    payload_bytes = '{SEL_UTF16_LE, BOM_FE, BOM_FF, 8'hd8, 8'h3d, 8'hde, 8'h00,
                      8'hd8, 8'h00, 8'h00, 8'h00, 8'h41};
    send_payload();
    // BE selector overridden to little-endian by FF FE; lone low surrogate;
    // high surrogate still pending at the end; odd trailing byte dropped.
    payload_bytes = '{SEL_UTF16_BE, BOM_FF, BOM_FE, 8'h00, 8'hdc, 8'h00, 8'hd8, 8'h41};
    send_payload();
    // Raw UTF-8: zero copied, trailing space kept in the length.
    payload_bytes = '{SEL_UTF8, 8'h00, CH_SPACE, 8'h80};
    send_payload();

    // Back-pressure: receiver holds off while the sender streams a long
    // Latin-1 run of two-byte characters without gaps, so full must assert.
    hold_requests++;
    steady_send = 1;
    payload_bytes.delete();
    payload_bytes.push_back(8'h05);
    repeat (40) payload_bytes.push_back(8'($urandom_range('h80, 'hff)));
    send_payload();
    steady_send = 0;
    wait_until_idle();

    run_random(16);

    // Capacity sweep: empty buffer, terminator only, saturation, the
    // ceiling, values right at the UTF-16 and Latin-1 thresholds, a random
    // middle value, and back to the reset value.
    caps = '{0, 1, 8191, 4096, 5, 6, 2, 9};
    caps.push_back($urandom_range(3, 300));
    caps.push_back(128);
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      run_random(10);
    end

    wait_until_idle();
    $display("Sent %0d bytes (%0d doing work) in %0d payloads over %0d capacity settings.",
             bytes_sent, counted_items, payloads, settings);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
sv/itt_pkg.sv
sv/itt_front.sv
sv/itt_cmd_fifo.sv
sv/itt_back.sv
sv/id3_text_to_utf8_transcoder.sv
tb/utf8_check_pkg.sv
tb/tb_id3_text_to_utf8_transcoder.sv
